// File: hdl/twg_pkg.sv
// Package for the table waveform generator: sizes, register indexes, wave and
// operation codes, and the fixed waveform ROM tables with their lookup functions.
// Depends on nothing; the interfaces and the top level import it.
package twg_pkg;

    // Sizes of the user store and the longest period.
    localparam int USER_DEPTH = 256;
    localparam int MAX_PERIOD = 512;

    localparam int UADDR_W  = (USER_DEPTH > 1) ? $clog2(USER_DEPTH) : 1;
    localparam int PHASE_W  = $clog2(MAX_PERIOD);
    localparam int PERIOD_W = $clog2(MAX_PERIOD + 1);

    // Field widths of the channels.
    localparam int OP_W       = 2;
    localparam int ADDR_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 12;
    localparam int POSITION_W = 9;
    localparam int WAVE_W     = 3;
    localparam int GAIN_W     = 18;
    localparam int OFFSET_W   = 12;
    localparam int VLEN_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Table geometry.
    localparam int COUNT_W  = 8;
    localparam int SMOOTH_W = 2;
    localparam int FRAC_W   = 2;
    localparam int CENTER_W = 13;
    localparam int PROD_W   = 32;
    localparam int SCALE_SH = 16;
    localparam int VOL_SH   = 16 - 12;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_LENGTH   = 2'd3;

    // Wave codes.
    localparam logic [WAVE_W-1:0] WAVE_DC       = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SINE_HQ  = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SINE_LQ  = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd4;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd5;
    localparam logic [WAVE_W-1:0] WAVE_CARDIAC  = 3'd6;
    localparam logic [WAVE_W-1:0] WAVE_VOLATILE = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [WAVE_W-1:0]   RST_WAVE   = WAVE_SINE_HQ;
    localparam logic [GAIN_W-1:0]   RST_GAIN   = 18'h10000;
    localparam logic [OFFSET_W-1:0] RST_OFFSET = 12'h800;
    localparam logic [VLEN_W-1:0]   RST_VLEN   = 9'd36;

    localparam logic [SAMPLE_W-1:0] MIDSCALE   = 12'h800;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hfff;
    localparam logic [BYTE_W:0]     USER_MID   = 9'd128;

    localparam logic [11:0] ROM_SINE [36] = '{
        12'h000, 12'h027, 12'h08E, 12'h130, 12'h209, 12'h311, 12'h441, 12'h58F, 12'h6F0,
        12'h85A, 12'h9C0, 12'hB19, 12'hC59, 12'hD76, 12'hE68, 12'hF26, 12'hFAB, 12'hFF3,
        12'hFFF, 12'hFD7, 12'hF70, 12'hECE, 12'hDF5, 12'hCED, 12'hBBD, 12'hA6F, 12'h90E,
        12'h7A4, 12'h63E, 12'h4E5, 12'h3A5, 12'h288, 12'h196, 12'h0D8, 12'h053, 12'h00B};

    localparam logic [11:0] ROM_TRIANGLE [36] = '{
        12'h000, 12'h0E3, 12'h1C6, 12'h2AA, 12'h38D, 12'h471, 12'h554, 12'h638, 12'h71B,
        12'h7FF, 12'h8E2, 12'h9C6, 12'hAA9, 12'hB8D, 12'hC70, 12'hD54, 12'hE37, 12'hF1B,
        12'hFFE, 12'hF1B, 12'hE37, 12'hD54, 12'hC70, 12'hB8D, 12'hAA9, 12'h9C6, 12'h8E2,
        12'h7FF, 12'h71B, 12'h638, 12'h554, 12'h471, 12'h38D, 12'h2AA, 12'h1C6, 12'h0E3};

    localparam logic [11:0] ROM_SAW [36] = '{
        12'h000, 12'h075, 12'h0EA, 12'h15F, 12'h1D4, 12'h249, 12'h2BE, 12'h333, 12'h3A8,
        12'h41D, 12'h492, 12'h507, 12'h57C, 12'h5F1, 12'h666, 12'h6DB, 12'h750, 12'h7C5,
        12'h83A, 12'h8AF, 12'h924, 12'h999, 12'hA0E, 12'hA83, 12'hAF8, 12'hB6D, 12'hBE2,
        12'hC57, 12'hCCC, 12'hD41, 12'hDB6, 12'hE2B, 12'hEA0, 12'hF15, 12'hF8A, 12'hFFF};

    localparam logic [11:0] ROM_SQUARE [2] = '{12'h000, 12'hfff};

    localparam logic [11:0] ROM_CARDIAC [128] = '{
        12'h3bd, 12'h397, 12'h391, 12'h391, 12'h396, 12'h393, 12'h3a2, 12'h3b3,
        12'h3b1, 12'h39f, 12'h38f, 12'h383, 12'h39b, 12'h3a3, 12'h3a0, 12'h3aa,
        12'h3ac, 12'h3bc, 12'h3d0, 12'h3f2, 12'h41c, 12'h439, 12'h425, 12'h401,
        12'h3f1, 12'h3c5, 12'h392, 12'h37a, 12'h374, 12'h37a, 12'h37f, 12'h386,
        12'h385, 12'h381, 12'h36c, 12'h385, 12'h3a1, 12'h39c, 12'h394, 12'h321,
        12'h176, 12'h1bf, 12'h3ad, 12'h728, 12'hc38, 12'hee3, 12'hfff, 12'h9f6,
        12'h410, 12'h181, 12'h000, 12'h0e0, 12'h154, 12'h1b8, 12'h1e8, 12'h219,
        12'h238, 12'h24f, 12'h288, 12'h2b8, 12'h2d6, 12'h2ed, 12'h319, 12'h33a,
        12'h34c, 12'h371, 12'h38f, 12'h3aa, 12'h3b7, 12'h3c7, 12'h3e4, 12'h3fc,
        12'h413, 12'h423, 12'h437, 12'h439, 12'h450, 12'h470, 12'h47f, 12'h48a,
        12'h482, 12'h48b, 12'h49a, 12'h499, 12'h48e, 12'h48a, 12'h477, 12'h44a,
        12'h426, 12'h3e6, 12'h386, 12'h324, 12'h2c3, 12'h280, 12'h25f, 12'h244,
        12'h234, 12'h233, 12'h235, 12'h251, 12'h275, 12'h295, 12'h2a6, 12'h2b0,
        12'h2c8, 12'h2e7, 12'h300, 12'h316, 12'h328, 12'h32e, 12'h32f, 12'h33f,
        12'h350, 12'h351, 12'h352, 12'h351, 12'h34a, 12'h356, 12'h35f, 12'h35d,
        12'h363, 12'h367, 12'h36b, 12'h377, 12'h384, 12'h37a, 12'h378, 12'h369};

    // Number of table entries of a wave; one for the modes without a table.
    function automatic logic [COUNT_W-1:0] wave_count(input logic [WAVE_W-1:0] sel);
        logic [COUNT_W-1:0] cnt;
        unique case (sel)
            WAVE_SINE_HQ, WAVE_SINE_LQ, WAVE_TRIANGLE, WAVE_SAW: cnt = 8'd36;
            WAVE_SQUARE:  cnt = 8'd2;
            WAVE_CARDIAC: cnt = 8'd128;
            default:      cnt = 8'd1;
        endcase
        return cnt;
    endfunction

    // Log2 of the interpolation steps between neighboring entries.
    function automatic logic [SMOOTH_W-1:0] wave_smooth(input logic [WAVE_W-1:0] sel);
        logic [SMOOTH_W-1:0] sm;
        unique case (sel)
            WAVE_SINE_HQ, WAVE_TRIANGLE, WAVE_SAW, WAVE_CARDIAC: sm = 2'd2;
            default: sm = 2'd0;
        endcase
        return sm;
    endfunction

    // Samples in one period of the selected wave.
    function automatic logic [PERIOD_W-1:0] wave_period(input logic [WAVE_W-1:0] sel,
                                                        input logic [VLEN_W-1:0] vlen);
        int n;
        if (sel == WAVE_VOLATILE) begin
            n = int'(vlen);
            if (n == 0) begin
                n = 1;
            end
            if (n > USER_DEPTH) begin
                n = USER_DEPTH;
            end
        end else begin
            n = int'(wave_count(sel)) << wave_smooth(sel);
        end
        if (n > MAX_PERIOD) begin
            n = MAX_PERIOD;
        end
        return PERIOD_W'(n);
    endfunction

    // ROM entry of a table wave; the index is below the wave's count.
    function automatic logic [SAMPLE_W-1:0] rom_entry(input logic [WAVE_W-1:0] sel,
                                                      input logic [6:0] idx);
        logic [SAMPLE_W-1:0] val;
        unique case (sel)
            WAVE_SINE_HQ, WAVE_SINE_LQ: val = ROM_SINE[idx[5:0]];
            WAVE_TRIANGLE: val = ROM_TRIANGLE[idx[5:0]];
            WAVE_SAW:      val = ROM_SAW[idx[5:0]];
            WAVE_SQUARE:   val = ROM_SQUARE[idx[0]];
            WAVE_CARDIAC:  val = ROM_CARDIAC[idx];
            default:       val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: hdl/twg_if.sv
// Channel interfaces of the table waveform generator: command input, sample
// output and configuration write. Depends on twg_pkg for the field widths.

interface twg_cmd_if import twg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [ADDR_W-1:0]   user_address;
    logic [BYTE_W-1:0]   user_byte;

    modport source (output valid, output operation, output user_address,
                    output user_byte, input ready);
    modport sink   (input valid, input operation, input user_address,
                    input user_byte, output ready);
endinterface

interface twg_smp_if import twg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [SAMPLE_W-1:0]   sample;
    logic [POSITION_W-1:0] position;
    logic                  period_end;

    modport source (output valid, output sample, output position,
                    output period_end, input ready);
    modport sink   (input valid, input sample, input position,
                    input period_end, output ready);
endinterface

interface twg_cfg_if import twg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/twg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module twg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/table_waveform_generator_unit.sv
// Top level of the table waveform generator: phase sequencing, ROM lookup,
// interpolation, scaling and saturation around the user sample store.
// Depends on twg_pkg, the interfaces in twg_if.sv and the RAM twg_ram.
//
//   Channel   Modport  Direction  Payload                               Handshake
//   i_cmd     sink     in         operation, user_address, user_byte    valid/ready
//   o_smp     source   out        sample, position, period_end          valid/ready
//   i_cfg     sink     in         index, data                           valid/ready
//
// A tick transaction passes these steps from acceptance to a loaded output register:
// acceptance with the phase update, ROM lookup and user store read; interpolation; the
// gain multiplier; scaling and saturation. Writes and restarts give no result.
// Reset is synchronous and active low and holds both ready outputs low; it restores the
// configuration defaults and clears the phase, while the user store keeps its contents.
// A waiting result does not block the next command; a second one stalls in the last stage.
module table_waveform_generator_unit import twg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    twg_cmd_if.sink    i_cmd,
    twg_smp_if.source  o_smp,
    twg_cfg_if.sink    i_cfg
);

    // One-hot sequencer of a tick through the datapath.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [WAVE_W-1:0]   r_wave;
    logic [GAIN_W-1:0]   r_gain;
    logic [OFFSET_W-1:0] r_offset;
    logic [VLEN_W-1:0]   r_vlen;

    // Phase within the period.
    logic [PHASE_W-1:0]  r_phase, n_phase;

    // Datapath registers carried along with a tick.
    logic [SAMPLE_W-1:0]        r_s0, r_s1;
    logic [FRAC_W-1:0]          r_frac;
    logic [POSITION_W-1:0]      r_pos;
    logic                       r_end;
    logic signed [CENTER_W-1:0] r_center;
    logic signed [PROD_W-1:0]   r_prod;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0]   r_out_sample;
    logic [POSITION_W-1:0] r_out_pos;
    logic                  r_out_end;

    logic cmd_fire;
    logic tick_fire;
    logic user_wr;
    logic out_load;

    // Phase and table index for the tick being accepted.
    logic [PERIOD_W-1:0] w_period;
    logic [PHASE_W-1:0]  w_p;
    logic [PERIOD_W-1:0] w_p_inc;
    logic                w_last;
    logic [31:0]         w_p32;
    logic [31:0]         w_addr32;
    logic [SMOOTH_W-1:0] w_smooth;
    logic [COUNT_W-1:0]  w_count;
    logic [PHASE_W-1:0]  w_idx;
    logic [PHASE_W-1:0]  w_idx_next;
    logic [FRAC_W-1:0]   w_frac;

    // Interpolation and centering.
    logic signed [CENTER_W-1:0] w_diff;
    logic signed [15:0]         w_step;
    logic signed [15:0]         w_step_sh;
    logic signed [13:0]         w_interp;
    logic signed [13:0]         w_tbl_c;
    logic [BYTE_W:0]            w_user_c;
    logic signed [CENTER_W-1:0] w_center;
    logic [BYTE_W-1:0]          ram_rd_data;

    // Scaling and saturation.
    logic signed [16:0]   w_sum;
    logic [SAMPLE_W-1:0]  w_sample;

    assign i_cmd.ready = i_rst_n && (r_state == ST_IDLE);
    assign i_cfg.ready = i_rst_n;
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;
    assign tick_fire   = cmd_fire && (i_cmd.operation == OP_TICK);

    // User store writes beyond the store are dropped.
    assign w_addr32 = 32'(i_cmd.user_address);
    assign user_wr  = cmd_fire && (i_cmd.operation == OP_WRITE)
                      && (w_addr32 < 32'(USER_DEPTH));

    // A stale phase after a change of wave or length restarts at position zero.
    always_comb begin
        w_period = wave_period(r_wave, r_vlen);
        w_p      = (32'(r_phase) >= 32'(w_period)) ? '0 : r_phase;
        w_p_inc  = PERIOD_W'(w_p) + PERIOD_W'(1);
        w_last   = (w_p_inc == w_period);
        w_p32    = 32'(w_p);
    end

    // Table index, its neighbor with wraparound to entry 0, and the fraction of the step between them.
    always_comb begin
        w_smooth = wave_smooth(r_wave);
        w_count  = wave_count(r_wave);
        w_idx    = w_p >> w_smooth;
        if (32'(w_idx) >= 32'(w_count)) begin
            w_idx = '0;
        end
        w_idx_next = w_idx + PHASE_W'(1);
        if (32'(w_idx_next) == 32'(w_count)) begin
            w_idx_next = '0;
        end
        w_frac = FRAC_W'(w_p & ((PHASE_W'(1) << w_smooth) - PHASE_W'(1)));
    end

    // The user store holds one sample per entry of the volatile wave. A write
    // and a read never meet in one cycle, since each comes from a command that is either a write or a tick.
    twg_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (USER_DEPTH)
    ) u_user_ram (
        .i_clk     (i_clk),
        .i_wr_en   (user_wr),
        .i_wr_addr (w_addr32[UADDR_W-1:0]),
        .i_wr_data (i_cmd.user_byte),
        .i_rd_en   (tick_fire),
        .i_rd_addr (w_p32[UADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // Linear interpolation with floor rounding, then centering on midscale.
    // User samples are centered on 128 and moved up four bits so that both
    // sources share the same gain shift.
    always_comb begin
        w_diff    = $signed({1'b0, r_s1}) - $signed({1'b0, r_s0});
        w_step    = $signed({{(16-CENTER_W){w_diff[CENTER_W-1]}}, w_diff})
                    * $signed({{(16-FRAC_W){1'b0}}, r_frac});
        w_step_sh = w_step >>> wave_smooth(r_wave);
        w_interp  = $signed({2'b00, r_s0}) + w_step_sh[13:0];
        w_tbl_c   = w_interp - $signed({2'b00, MIDSCALE});
        w_user_c  = {1'b0, ram_rd_data} - USER_MID;
        if (r_wave == WAVE_VOLATILE) begin
            w_center = $signed({w_user_c, VOL_SH'(0)});
        end else begin
            w_center = w_tbl_c[CENTER_W-1:0];
        end
    end

    // The arithmetic shift of the product is a floor division by 2^16.
    always_comb begin
        w_sum = $signed({r_prod[PROD_W-1], r_prod[PROD_W-1:SCALE_SH]})
                + $signed({5'b00000, r_offset});
        if (r_wave == WAVE_DC) begin
            w_sample = r_offset;
        end else if (w_sum < 0) begin
            w_sample = '0;
        end else if (w_sum > $signed({5'b00000, SAMPLE_MAX})) begin
            w_sample = SAMPLE_MAX;
        end else begin
            w_sample = w_sum[SAMPLE_W-1:0];
        end
    end

    assign out_load = (r_state == ST_OUT) && (!r_out_valid || o_smp.ready);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_smp.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (tick_fire) begin
                    n_state = ST_FETCH;
                    n_phase = w_last ? '0 : w_p_inc[PHASE_W-1:0];
                end else if (cmd_fire && (i_cmd.operation == OP_RESTART)) begin
                    n_phase = '0;
                end
            end
            ST_FETCH: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            r_wave      <= RST_WAVE;
            r_gain      <= RST_GAIN;
            r_offset    <= RST_OFFSET;
            r_vlen      <= RST_VLEN;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_WAVE_SELECT:  r_wave   <= i_cfg.data[WAVE_W-1:0];
                    CFG_GAIN:         r_gain   <= i_cfg.data[GAIN_W-1:0];
                    CFG_LEVEL_OFFSET: r_offset <= i_cfg.data[OFFSET_W-1:0];
                    CFG_VOL_LENGTH:   r_vlen   <= i_cfg.data[VLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        if (tick_fire) begin
            r_s0   <= rom_entry(r_wave, w_idx[6:0]);
            r_s1   <= rom_entry(r_wave, w_idx_next[6:0]);
            r_frac <= w_frac;
            r_pos  <= w_p32[POSITION_W-1:0];
            r_end  <= w_last;
        end
        if (r_state == ST_FETCH) begin
            r_center <= w_center;
        end
        if (r_state == ST_MUL) begin
            r_prod <= $signed({{(PROD_W-CENTER_W){r_center[CENTER_W-1]}}, r_center})
                      * $signed({{(PROD_W-GAIN_W){1'b0}}, r_gain});
        end
        if (out_load) begin
            r_out_sample <= w_sample;
            r_out_pos    <= r_pos;
            r_out_end    <= r_end;
        end
    end

    assign o_smp.valid      = r_out_valid;
    assign o_smp.sample     = r_out_sample;
    assign o_smp.position   = r_out_pos;
    assign o_smp.period_end = r_out_end;

endmodule
